### hdl/ump_pkg.sv
// Package for the upwind momentum flux correction core: types, constants, helpers.
package ump_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned SumW        = 66;

  typedef struct packed {
    logic [1:0]         action;
    logic               line_start;
    logic signed [31:0] vel_one;
    logic signed [31:0] vel_two;
    logic signed [31:0] vel_three;
    logic signed [31:0] face_flux;
    logic signed [31:0] trans_a_low;
    logic signed [31:0] trans_a_high;
    logic signed [31:0] trans_b_low;
    logic signed [31:0] trans_b_high;
  } ump_in_t;

  typedef struct packed {
    logic signed [31:0] incr_one;
    logic signed [31:0] incr_two;
    logic signed [31:0] incr_three;
  } ump_out_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } mdu_op_e;

  typedef struct packed {
    logic    start;
    mdu_op_e op;
  } mdu_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_VL_MUL,
    ST_VL_DIV,
    ST_ADV,
    ST_OUT
  } ump_state_e;

  function automatic logic [31:0] mag32(logic signed [31:0] x);
    logic [31:0] r;
    r = x[31] ? 32'(-x) : 32'(x);
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [SumW-1:0] v);
    logic signed [31:0] r;
    if (v > $signed({{(SumW-32){1'b0}}, 32'h7fff_ffff})) begin
      r = 32'sh7fff_ffff;
    end else if (v < $signed({{(SumW-32){1'b1}}, 32'h8000_0000})) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### hdl/upwind_momentum_flux_correction_core.sv
// Top level of the upwind momentum flux correction core: sequencer and state.
// An item that gives no result (first cell of a line, no previous cell, or an
// inactive direction) is only stored, and the input stays ready. An item that
// closes a face runs on the one shared multiply/divide unit: three multiplies
// for the diffusion terms, then for each transverse direction with same-sign
// normal velocities one multiply, one divide and one multiply for the Van Leer
// advection term. Each operation is launched by a start command and ends with
// the unit's registered done. A limiter that is zero skips its multiply and
// divide. The input is not ready until the result is loaded into the output
// register, which waits while an earlier result has not been taken.
module upwind_momentum_flux_correction_core #(
  parameter int unsigned FRAC_BITS = ump_pkg::FracBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ump_pkg::ump_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ump_pkg::ump_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_data_i
);

  localparam int unsigned SumW = ump_pkg::SumW;

  ump_pkg::ump_state_e state_q, state_d;
  ump_pkg::ump_in_t    cur_q;
  logic signed [31:0]  prv_vel_q [3];
  logic signed [31:0]  prv_tr_q  [4];
  logic                prv_valid_q;
  logic [1:0]          act_dims_q;
  logic [1:0]          idx_q;
  logic signed [SumW-1:0] sum_q [3];
  logic signed [31:0]  lv_q;
  logic                launched_q;
  ump_pkg::ump_out_t   out_q;
  logic                out_valid_q;

  ump_pkg::mdu_cmd_t   cmd;
  logic [63:0]         opa;
  logic [32:0]         opb;
  logic                mdu_done;
  logic [63:0]         mdu_res;

  logic                in_acc;
  logic                emit;
  logic                step_done;
  logic                out_load;
  logic signed [31:0]  cur_vel [3];
  logic signed [31:0]  up_v;
  logic signed [31:0]  vp, vc;
  logic                same;
  logic [1:0]          ta, tb, tk;
  logic signed [31:0]  pa, pb;
  logic                vl_pos, vl_neg, vl_ok;
  logic                prod_neg;
  logic signed [64:0]  prod_s;
  logic signed [64:0]  term;
  logic [63:0]         q;
  logic signed [31:0]  lv_sat;

  always_comb begin
    cur_vel[0] = cur_q.vel_one;
    cur_vel[1] = cur_q.vel_two;
    cur_vel[2] = cur_q.vel_three;
    case (idx_q)
      2'd0:    up_v = (cur_q.face_flux >= 0) ? prv_vel_q[0] : cur_vel[0];
      2'd1:    up_v = (cur_q.face_flux >= 0) ? prv_vel_q[1] : cur_vel[1];
      default: up_v = (cur_q.face_flux >= 0) ? prv_vel_q[2] : cur_vel[2];
    endcase
    case (cur_q.action)
      2'd0:    begin vp = prv_vel_q[0]; vc = cur_vel[0]; end
      2'd1:    begin vp = prv_vel_q[1]; vc = cur_vel[1]; end
      default: begin vp = prv_vel_q[2]; vc = cur_vel[2]; end
    endcase
    same = !((vp < 0 && vc > 0) || (vp > 0 && vc < 0));
    ta   = (cur_q.action == 2'd0) ? 2'd1 : 2'd0;
    tb   = (cur_q.action == 2'd2) ? 2'd1 : 2'd2;
    tk   = idx_q[0] ? tb : ta;
    pa   = idx_q[0] ? prv_tr_q[3] : prv_tr_q[1];
    pb   = idx_q[0] ? prv_tr_q[2] : prv_tr_q[0];
    vl_pos = pa > 0 && pb > 0;
    vl_neg = pa < 0 && pb < 0;
    vl_ok  = vl_pos || vl_neg;

    in_acc = in_valid_i && in_ready_o;
    emit   = !in_data_i.line_start && prv_valid_q && (in_data_i.action != 2'd3) &&
             (in_data_i.action < act_dims_q);
    step_done = launched_q && mdu_done;
    out_load  = (state_q == ump_pkg::ST_OUT) && (!out_valid_q || out_ready_i);

    prod_neg = (state_q == ump_pkg::ST_DIFF) ? (cur_q.face_flux[31] ^ up_v[31])
                                             : (vc[31] ^ lv_q[31]);
    prod_s   = prod_neg ? -$signed({1'b0, mdu_res}) : $signed({1'b0, mdu_res});
    if ((state_q == ump_pkg::ST_DIFF) && (idx_q == cur_q.action)) begin
      term = prod_s >>> (FRAC_BITS - 1);
    end else begin
      term = prod_s >>> FRAC_BITS;
    end

    q = mdu_res;
    if (vl_pos) begin
      lv_sat = (q > 64'h7fff_ffff) ? 32'sh7fff_ffff : $signed(q[31:0]);
    end else begin
      lv_sat = (q > 64'h8000_0000) ? 32'sh8000_0000 : $signed(32'(-q[31:0]));
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ump_pkg::ST_IDLE: begin
        if (in_acc && emit) state_d = ump_pkg::ST_DIFF;
      end
      ump_pkg::ST_DIFF: begin
        if (step_done && idx_q == 2'd2) begin
          state_d = same ? ump_pkg::ST_VL_MUL : ump_pkg::ST_OUT;
        end
      end
      ump_pkg::ST_VL_MUL: begin
        if (!vl_ok) state_d = ump_pkg::ST_ADV;
        else if (step_done) state_d = ump_pkg::ST_VL_DIV;
      end
      ump_pkg::ST_VL_DIV: begin
        if (step_done) state_d = ump_pkg::ST_ADV;
      end
      ump_pkg::ST_ADV: begin
        if (step_done) state_d = idx_q[0] ? ump_pkg::ST_OUT : ump_pkg::ST_VL_MUL;
      end
      ump_pkg::ST_OUT: begin
        if (out_load) state_d = ump_pkg::ST_IDLE;
      end
      default: state_d = ump_pkg::ST_IDLE;
    endcase
  end

  // unit commands and operands
  always_comb begin
    cmd.start  = 1'b0;
    cmd.op     = ump_pkg::OP_MUL;
    opa        = '0;
    opb        = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ump_pkg::ST_IDLE: in_ready_o = 1'b1;
      ump_pkg::ST_DIFF: begin
        cmd.start = !launched_q;
        opa = {32'd0, ump_pkg::mag32(cur_q.face_flux)};
        opb = {1'b0, ump_pkg::mag32(up_v)};
      end
      ump_pkg::ST_VL_MUL: begin
        cmd.start = !launched_q && vl_ok;
        opa = {32'd0, ump_pkg::mag32(pa)};
        opb = {1'b0, ump_pkg::mag32(pb)};
      end
      ump_pkg::ST_VL_DIV: begin
        cmd.start = !launched_q;
        cmd.op    = ump_pkg::OP_DIV;
        opa = {mdu_res[62:0], 1'b0};
        opb = {1'b0, ump_pkg::mag32(pa)} + {1'b0, ump_pkg::mag32(pb)};
      end
      ump_pkg::ST_ADV: begin
        cmd.start = !launched_q;
        opa = {32'd0, ump_pkg::mag32(vc)};
        opb = {1'b0, ump_pkg::mag32(lv_q)};
      end
      default: ;
    endcase
  end

  ump_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .opa_i  (opa),
    .opb_i  (opb),
    .done_o (mdu_done),
    .res_o  (mdu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ump_pkg::ST_IDLE;
      prv_valid_q <= 1'b0;
      act_dims_q  <= 2'd3;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      for (int i = 0; i < 3; i++) prv_vel_q[i] <= '0;
      for (int i = 0; i < 4; i++) prv_tr_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) act_dims_q <= cfg_data_i;
      if (cmd.start) launched_q <= 1'b1;
      else if (mdu_done) launched_q <= 1'b0;

      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      case (state_q)
        ump_pkg::ST_IDLE: begin
          idx_q <= '0;
          if (in_acc && !emit) begin
            // store the cell, no face to close
            prv_valid_q <= 1'b1;
            prv_vel_q[0] <= in_data_i.vel_one;
            prv_vel_q[1] <= in_data_i.vel_two;
            prv_vel_q[2] <= in_data_i.vel_three;
            prv_tr_q[0]  <= in_data_i.trans_a_low;
            prv_tr_q[1]  <= in_data_i.trans_a_high;
            prv_tr_q[2]  <= in_data_i.trans_b_low;
            prv_tr_q[3]  <= in_data_i.trans_b_high;
          end
        end
        ump_pkg::ST_DIFF: begin
          if (step_done) idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        end
        ump_pkg::ST_ADV: begin
          if (step_done) idx_q <= 2'd1;
        end
        ump_pkg::ST_OUT: begin
          if (out_load) begin
            prv_valid_q  <= 1'b1;
            prv_vel_q[0] <= cur_q.vel_one;
            prv_vel_q[1] <= cur_q.vel_two;
            prv_vel_q[2] <= cur_q.vel_three;
            prv_tr_q[0]  <= cur_q.trans_a_low;
            prv_tr_q[1]  <= cur_q.trans_a_high;
            prv_tr_q[2]  <= cur_q.trans_b_low;
            prv_tr_q[3]  <= cur_q.trans_b_high;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) cur_q <= in_data_i;
    case (state_q)
      ump_pkg::ST_DIFF: begin
        if (step_done) sum_q[idx_q] <= {{(SumW-65){term[64]}}, term};
      end
      ump_pkg::ST_VL_MUL: begin
        if (!vl_ok) lv_q <= '0;
      end
      ump_pkg::ST_VL_DIV: begin
        if (step_done) lv_q <= lv_sat;
      end
      ump_pkg::ST_ADV: begin
        if (step_done) sum_q[tk] <= sum_q[tk] + {{(SumW-65){term[64]}}, term};
      end
      ump_pkg::ST_OUT: begin
        if (out_load) begin
          out_q.incr_one   <= ump_pkg::sat32(sum_q[0]);
          out_q.incr_two   <= ump_pkg::sat32(sum_q[1]);
          out_q.incr_three <= ump_pkg::sat32(sum_q[2]);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_done_launched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_done |-> launched_q)
    else $error("unit finished without a launched operation");

  a_ready_idle_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !launched_q)
    else $error("input ready while the shared unit is busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("pending result changed before it was taken");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ump_pkg::ST_DIFF) |-> (idx_q[1] == 1'b0))
    else $error("transverse step index out of range");

endmodule

### hdl/ump_mdu.sv
// Shared iterative unit: unsigned 32x32 multiply and 64/33 restoring divide, one bit a cycle.
module ump_mdu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ump_pkg::mdu_cmd_t cmd_i,
  input  logic [63:0]       opa_i,
  input  logic [32:0]       opb_i,
  output logic              done_o,
  output logic [63:0]       res_o
);

  logic              busy_q;
  logic              done_q;
  logic [5:0]        cnt_q;
  ump_pkg::mdu_op_e  op_q;
  logic [33:0]       hi_q;
  logic [63:0]       lo_q;
  logic [32:0]       opnd_q;

  logic [33:0] mul_t;
  logic [33:0] div_r;
  logic        div_ge;
  logic        last;

  always_comb begin
    mul_t  = {1'b0, hi_q[32:0]} + (lo_q[0] ? {1'b0, opnd_q} : 34'd0);
    div_r  = {hi_q[32:0], lo_q[63]};
    div_ge = div_r >= {1'b0, opnd_q};
    last   = (op_q == ump_pkg::OP_MUL) ? (cnt_q == 6'd31) : (cnt_q == 6'd63);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ump_pkg::OP_MUL;
    end else begin
      done_q <= busy_q && last;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        op_q   <= cmd_i.op;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      hi_q <= '0;
      if (cmd_i.op == ump_pkg::OP_MUL) begin
        lo_q   <= {32'd0, opb_i[31:0]};
        opnd_q <= {1'b0, opa_i[31:0]};
      end else begin
        lo_q   <= opa_i;
        opnd_q <= opb_i;
      end
    end else if (busy_q) begin
      if (op_q == ump_pkg::OP_MUL) begin
        // add then shift the double-width product right
        hi_q        <= {1'b0, mul_t[33:1]};
        lo_q[31:0]  <= {mul_t[0], lo_q[31:1]};
      end else begin
        hi_q <= div_ge ? (div_r - {1'b0, opnd_q}) : div_r;
        lo_q <= {lo_q[62:0], div_ge};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == ump_pkg::OP_MUL) ? {hi_q[31:0], lo_q[31:0]} : lo_q;

endmodule

### dv/tb.sv
// Self-checking testbench for the upwind momentum flux correction core.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned FRAC = 16;
  localparam int unsigned DRAIN_CYCLES = 400;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  ump_pkg::ump_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  ump_pkg::ump_out_t out_data_o;
  logic     cfg_we_i;
  logic [1:0] cfg_data_i;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned items_sent;

  upwind_momentum_flux_correction_core #(.FRAC_BITS(FRAC)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  class flux_scoreboard;
    logic [1:0] dims;
    longint     last_vel[3];
    longint     last_trans[4];
    bit         have_last;
    ump_pkg::ump_out_t expected_incr[$];
    int unsigned errors;
    int unsigned n_requests;
    int unsigned n_faces;

    function new();
      dims = 2'd3;
      have_last = 1'b0;
      foreach (last_vel[i]) last_vel[i] = 0;
      foreach (last_trans[i]) last_trans[i] = 0;
      errors = 0;
      n_requests = 0;
      n_faces = 0;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Harmonic-style limiter; zero unless both fluxes share a strict sign.
    function longint limiter(longint a, longint b);
      bit pos;
      bit [63:0] ma, mb, q;
      pos = (a > 0) && (b > 0);
      if (!pos && !((a < 0) && (b < 0))) return 0;
      ma = pos ? a : -a;
      mb = pos ? b : -b;
      q = (64'd2 * ma * mb) / (ma + mb);
      if (pos) return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
      return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
    endfunction

    function void note_request(ump_pkg::ump_in_t r);
      longint vel[3], tr[4], up[3], sum[3];
      longint flux, vp, vc, p;
      int ta, tb;
      int d;
      ump_pkg::ump_out_t e;
      n_requests++;
      d = r.action;
      vel[0] = longint'(r.vel_one);
      vel[1] = longint'(r.vel_two);
      vel[2] = longint'(r.vel_three);
      tr[0] = longint'(r.trans_a_low);
      tr[1] = longint'(r.trans_a_high);
      tr[2] = longint'(r.trans_b_low);
      tr[3] = longint'(r.trans_b_high);
      flux = longint'(r.face_flux);
      if (!r.line_start && have_last && d < 3 && d < dims) begin
        foreach (up[c]) up[c] = (flux >= 0) ? last_vel[c] : vel[c];
        vp = last_vel[d];
        vc = vel[d];
        ta = (d == 0) ? 1 : 0;
        tb = (d == 2) ? 1 : 2;
        for (int c = 0; c < 3; c++) begin
          p = flux * up[c];
          sum[c] = (c == d) ? (p >>> (FRAC - 1)) : (p >>> FRAC);
        end
        if (!((vp < 0 && vc > 0) || (vp > 0 && vc < 0))) begin
          sum[ta] += (vc * limiter(last_trans[1], last_trans[0])) >>> FRAC;
          sum[tb] += (vc * limiter(last_trans[3], last_trans[2])) >>> FRAC;
        end
        e.incr_one   = 32'(clamp32(sum[0]));
        e.incr_two   = 32'(clamp32(sum[1]));
        e.incr_three = 32'(clamp32(sum[2]));
        expected_incr.push_back(e);
      end
      foreach (vel[i]) last_vel[i] = vel[i];
      foreach (tr[i]) last_trans[i] = tr[i];
      have_last = 1'b1;
    endfunction

    function void check_result(ump_pkg::ump_out_t got);
      ump_pkg::ump_out_t e;
      if (expected_incr.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = expected_incr.pop_front();
      n_faces++;
      if (got.incr_one !== e.incr_one) begin
        $display("%0t: incr_one expected %h got %h", $time, e.incr_one, got.incr_one);
        errors++;
      end
      if (got.incr_two !== e.incr_two) begin
        $display("%0t: incr_two expected %h got %h", $time, e.incr_two, got.incr_two);
        errors++;
      end
      if (got.incr_three !== e.incr_three) begin
        $display("%0t: incr_three expected %h got %h", $time, e.incr_three, got.incr_three);
        errors++;
      end
    endfunction
  endclass

  flux_scoreboard sb = new();

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_request(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      3: return $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
      4, 5: return $urandom;
      default: return $urandom_range(0, 1) ? $signed($urandom_range(0, 32'h4_0000))
                                           : -$signed($urandom_range(0, 32'h4_0000));
    endcase
  endfunction

  function automatic ump_pkg::ump_in_t make_cell(logic [1:0] dir, logic first, int v1, int v2,
                                                 int v3, int f, int al, int ah, int bl,
                                                 int bh);
    ump_pkg::ump_in_t r;
    r.action = dir;
    r.line_start = first;
    r.vel_one = v1;
    r.vel_two = v2;
    r.vel_three = v3;
    r.face_flux = f;
    r.trans_a_low = al;
    r.trans_a_high = ah;
    r.trans_b_low = bl;
    r.trans_b_high = bh;
    return r;
  endfunction

  function automatic ump_pkg::ump_in_t random_cell(logic [1:0] dir, logic first);
    return make_cell(dir, first, pick_value(), pick_value(), pick_value(), pick_value(),
                     pick_value(), pick_value(), pick_value(), pick_value());
  endfunction

  task automatic send_request(ump_pkg::ump_in_t r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_incr.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_dims(logic [1:0] v);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.dims = v;
  endtask

  // One stream line: a start cell, then cells along the same axis, with
  // occasional noise (stray line starts, axis changes, inactive axis).
  task automatic send_line();
    logic [1:0] dir;
    int len;
    logic first;
    dir = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    len = $urandom_range(2, 6);
    for (int i = 0; i < len; i++) begin
      first = (i == 0) || ($urandom_range(0, 19) == 0);
      if ($urandom_range(0, 19) == 0) dir = 2'($urandom_range(0, 3));
      send_request(random_cell(dir, first));
    end
  endtask

  task automatic run_phase(logic [1:0] dims, int unsigned idle, int unsigned stall,
                           int unsigned n);
    int unsigned target;
    drain();
    write_dims(dims);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    target = items_sent + n;
    while (items_sent < target) send_line();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = 2'd0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: first cell after reset, both upwind choices, sign cases,
    // every axis, inactive axis, saturation, mid-line restart, axis change.
    send_request(make_cell(2'd0, 1'b0, 32'h10000, 32'h20000, 32'h30000, 32'h8000,
                           32'h10000, 32'h20000, 32'h30000, 32'h40000));
    send_request(make_cell(2'd0, 1'b0, 32'h18000, -32'h10000, 32'h4000, 32'h20000,
                           -32'h10000, -32'h30000, 32'h10000, -32'h10000));
    send_request(make_cell(2'd0, 1'b0, 32'h8000, 32'h1000, -32'h2000, -32'h18000,
                           32'h5000, 32'h7000, 32'h0, 32'h9000));
    send_request(make_cell(2'd0, 1'b0, -32'h8000, 32'h1000, 32'h2000, 32'h10000,
                           32'h1000, 32'h1000, 32'h2000, 32'h2000));
    send_request(make_cell(2'd0, 1'b0, 32'h0, 32'h3000, 32'h5000, 32'h10000,
                           32'h4000, 32'h8000, -32'h4000, -32'h8000));
    send_request(make_cell(2'd1, 1'b1, 32'h1000, 32'h2000, 32'h3000, 32'h1000,
                           32'h6000, 32'h2000, 32'h1000, 32'h3000));
    send_request(make_cell(2'd1, 1'b0, 32'h2000, 32'h4000, 32'h1000, -32'h3000,
                           32'h1000, 32'h2000, 32'h3000, 32'h4000));
    send_request(make_cell(2'd2, 1'b0, 32'h2000, 32'h4000, 32'h1000, 32'h3000,
                           32'h2000, 32'h2000, 32'h5000, 32'h3000));
    send_request(make_cell(2'd2, 1'b0, -32'h2000, 32'h4000, -32'h1000, 32'h3000,
                           32'h2000, 32'h2000, 32'h5000, 32'h3000));
    send_request(make_cell(2'd3, 1'b0, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1));
    send_request(make_cell(2'd0, 1'b0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           32'h7fffffff));
    send_request(make_cell(2'd0, 1'b0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
                           32'h80000000));
    send_request(make_cell(2'd0, 1'b0, 32'h80000000, 32'h80000000, 32'h80000000,
                           32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                           32'h80000000));
    send_request(make_cell(2'd1, 1'b0, 32'h80000000, 32'h80000000, 32'h80000000,
                           32'h7fffffff, 32'hffffffff, 32'h1, 32'h0, 32'h0));
    send_request(make_cell(2'd2, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    send_request(make_cell(2'd2, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    send_request(make_cell(2'd0, 1'b0, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                           32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                           32'hffffffff));
    send_request(make_cell(2'd1, 1'b0, 32'h1, 32'h1, 32'h1, 32'hffffffff, 32'h1, 32'h1,
                           32'h1, 32'h1));

    run_phase(2'd3, 0, 0, 200);
    run_phase(2'd1, 67, 0, 150);
    run_phase(2'd2, 0, 67, 200);
    run_phase(2'd0, 30, 30, 60);
    run_phase(2'd3, 30, 30, 150);
    // Hold the sender until the block has delivered everything outstanding.
    drain();
    run_phase(2'd3, 67, 67, 250);
    run_phase(2'd2, 0, 0, 220);
    drain();

    $display("Sent %0d cells, checked %0d face increments over active_dims 0..3.",
             sb.n_requests, sb.n_faces);
    $display("Sender gaps and receiver stalls ran at 0, 30 and 67 percent.");
    if (sb.errors == 0 && sb.expected_incr.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
